// ===== hw/rtl/pzm_pkg.sv =====
// Shared constants, codes and types for the polygon zone membership block.
// No dependencies; imported by every module of the block.

package pzm_pkg;

   // fixed port widths
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int PORT_COORD_W = 32;
   localparam int ZONES_OUT_W = 5;

   // defaults for the top-level parameters
   localparam int DEF_VERTEX_DEPTH = 256;
   localparam int DEF_ZONE_DEPTH   = 16;
   localparam int DEF_COORD_BITS   = 32;

   // smallest polygon that is kept as a zone
   localparam int MIN_POLY_VERTICES = 3;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_ENABLED = '0;

   // request modes
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   // response status
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // tag that travels with one polygon edge through the crossing test
   typedef struct packed {
      logic valid;
      logic zone_end;
   } edge_ctl_type;

endpackage

// ===== hw/rtl/pzm_edge_walk.sv =====
// Vertex memory and the sequencer that walks it, producing one polygon edge a cycle,
// but none for the vertex that opens each zone. Depends on pzm_pkg.

module pzm_edge_walk #(
   parameter int VERTEX_DEPTH = pzm_pkg::DEF_VERTEX_DEPTH,
   parameter int COORD_BITS   = pzm_pkg::DEF_COORD_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic [$clog2(VERTEX_DEPTH)-1:0]       wr_addr,
   input  logic signed [COORD_BITS-1:0]          wr_x,
   input  logic signed [COORD_BITS-1:0]          wr_y,
   input  logic                                  wr_last,
   input  logic                                  start,
   input  logic [$clog2(VERTEX_DEPTH+1)-1:0]     vtx_count,
   output pzm_pkg::edge_ctl_type                 edge_ctl,
   output logic signed [COORD_BITS-1:0]          exi,
   output logic signed [COORD_BITS-1:0]          eyi,
   output logic signed [COORD_BITS-1:0]          exj,
   output logic signed [COORD_BITS-1:0]          eyj,
   output logic                                  busy
);
   import pzm_pkg::*;

   localparam int AW = $clog2(VERTEX_DEPTH);
   localparam int CW = $clog2(VERTEX_DEPTH + 1);
   localparam int MW = 2 * COORD_BITS + 1;

   logic [MW-1:0] vtx_mem [VERTEX_DEPTH];
   logic [MW-1:0] rd_data_ff;

   logic          walking_ff, walking_in;
   logic [CW-1:0] rd_addr_ff, rd_addr_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          close_ff, close_in;
   logic          zone_start_ff, zone_start_in;
   logic signed [COORD_BITS-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   edge_ctl_type edge_ctl_ff, edge_ctl_in;
   logic signed [COORD_BITS-1:0] exi_ff, exi_in, eyi_ff, eyi_in;
   logic signed [COORD_BITS-1:0] exj_ff, exj_in, eyj_ff, eyj_in;

   logic signed [COORD_BITS-1:0] cur_x, cur_y;
   logic                         cur_last;
   logic                         rd_en;

   assign cur_x    = rd_data_ff[COORD_BITS-1:0];
   assign cur_y    = rd_data_ff[2*COORD_BITS-1:COORD_BITS];
   assign cur_last = rd_data_ff[MW-1];

   // hold off the next read while the closing edge of a zone goes out
   assign rd_en = walking_ff && (rd_addr_ff < vtx_count) && !(rd_valid_ff && cur_last);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vtx_mem[wr_addr] <= {wr_last, wr_y, wr_x};
      end
      if (rd_en) begin
         rd_data_ff <= vtx_mem[rd_addr_ff[AW-1:0]];
      end
   end

   always_comb begin
      walking_in    = walking_ff;
      rd_addr_in    = CW'(rd_addr_ff + CW'(rd_en));
      rd_valid_in   = rd_en;
      close_in      = 1'b0;
      zone_start_in = zone_start_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      edge_ctl_in   = '0;
      exi_in        = exi_ff;
      eyi_in        = eyi_ff;
      exj_in        = exj_ff;
      eyj_in        = eyj_ff;

      if (rd_valid_ff) begin
         prev_x_in = cur_x;
         prev_y_in = cur_y;
         if (zone_start_ff) begin
            first_x_in    = cur_x;
            first_y_in    = cur_y;
            zone_start_in = 1'b0;
         end else begin
            edge_ctl_in.valid = 1'b1;
            exi_in            = cur_x;
            eyi_in            = cur_y;
            exj_in            = prev_x_ff;
            eyj_in            = prev_y_ff;
            close_in          = cur_last;
            zone_start_in     = cur_last;
         end
      end else if (close_ff) begin
         // closing edge: first vertex against the last one
         edge_ctl_in.valid    = 1'b1;
         edge_ctl_in.zone_end = 1'b1;
         exi_in               = first_x_ff;
         eyi_in               = first_y_ff;
         exj_in               = prev_x_ff;
         eyj_in               = prev_y_ff;
      end

      if (walking_ff && (rd_addr_ff == vtx_count) && !rd_valid_ff && !close_ff) begin
         walking_in = 1'b0;
      end

      if (start) begin
         walking_in    = 1'b1;
         rd_addr_in    = '0;
         zone_start_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walking_ff    <= 1'b0;
         rd_addr_ff    <= '0;
         rd_valid_ff   <= 1'b0;
         close_ff      <= 1'b0;
         zone_start_ff <= 1'b1;
         edge_ctl_ff   <= '0;
      end else begin
         walking_ff    <= walking_in;
         rd_addr_ff    <= rd_addr_in;
         rd_valid_ff   <= rd_valid_in;
         close_ff      <= close_in;
         zone_start_ff <= zone_start_in;
         edge_ctl_ff   <= edge_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      exi_ff     <= exi_in;
      eyi_ff     <= eyi_in;
      exj_ff     <= exj_in;
      eyj_ff     <= eyj_in;
   end

   assign edge_ctl = edge_ctl_ff;
   assign exi      = exi_ff;
   assign eyi      = eyi_ff;
   assign exj      = exj_ff;
   assign eyj      = eyj_ff;
   assign busy     = walking_ff || rd_valid_ff || close_ff || edge_ctl_ff.valid;

endmodule

// ===== hw/rtl/pzm_cross_test.sv =====
// Pipelined crossing-number edge test: differences, split partial products,
// product sums, then exact compare and per-zone parity. Depends on pzm_pkg.

module pzm_cross_test #(
   parameter int COORD_BITS = pzm_pkg::DEF_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  pzm_pkg::edge_ctl_type        edge_ctl,
   input  logic signed [COORD_BITS-1:0] exi,
   input  logic signed [COORD_BITS-1:0] eyi,
   input  logic signed [COORD_BITS-1:0] exj,
   input  logic signed [COORD_BITS-1:0] eyj,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   output logic                         any_hit,
   output logic                         busy
);
   import pzm_pkg::*;

   localparam int W  = COORD_BITS + 1;
   localparam int H  = (W + 1) / 2;
   localparam int HW = W - H;
   localparam int P  = 2 * W;

   // stage A: differences
   edge_ctl_type        ctl_a_ff;
   logic                cross_a_ff, cross_a_in, dpos_a_ff, dpos_a_in;
   logic signed [W-1:0] a_ff, a_in, d_ff, d_in, b_ff, b_in, c_ff, c_in;

   assign a_in       = W'(px) - W'(exi);
   assign d_in       = W'(eyj) - W'(eyi);
   assign b_in       = W'(exj) - W'(exi);
   assign c_in       = W'(py) - W'(eyi);
   assign cross_a_in = (eyi > py) != (eyj > py);
   assign dpos_a_in  = eyj > eyi;

   // stage B: partial products of a*d and b*c
   logic signed [HW-1:0] a_hi, d_hi, b_hi, c_hi;
   logic signed [H:0]    a_lo, d_lo, b_lo, c_lo;

   assign a_hi = a_ff[W-1:H];
   assign d_hi = d_ff[W-1:H];
   assign b_hi = b_ff[W-1:H];
   assign c_hi = c_ff[W-1:H];
   assign a_lo = {1'b0, a_ff[H-1:0]};
   assign d_lo = {1'b0, d_ff[H-1:0]};
   assign b_lo = {1'b0, b_ff[H-1:0]};
   assign c_lo = {1'b0, c_ff[H-1:0]};

   edge_ctl_type               ctl_b_ff;
   logic                       cross_b_ff, dpos_b_ff;
   logic signed [2*HW-1:0]     phh_ff, phh_in, qhh_ff, qhh_in;
   logic signed [HW+H:0]       phl_ff, phl_in, plh_ff, plh_in;
   logic signed [HW+H:0]       qhl_ff, qhl_in, qlh_ff, qlh_in;
   logic signed [2*H+1:0]      pll_ff, pll_in, qll_ff, qll_in;

   assign phh_in = a_hi * d_hi;
   assign phl_in = a_hi * d_lo;
   assign plh_in = a_lo * d_hi;
   assign pll_in = a_lo * d_lo;
   assign qhh_in = b_hi * c_hi;
   assign qhl_in = b_hi * c_lo;
   assign qlh_in = b_lo * c_hi;
   assign qll_in = b_lo * c_lo;

   // stage C: full products
   edge_ctl_type        ctl_c_ff;
   logic                cross_c_ff, dpos_c_ff;
   logic signed [P-1:0] lhs_ff, lhs_in, rhs_ff, rhs_in;

   assign lhs_in = (P'(phh_ff) <<< (2 * H)) + (P'(phl_ff) <<< H) + (P'(plh_ff) <<< H)
                   + P'(pll_ff);
   assign rhs_in = (P'(qhh_ff) <<< (2 * H)) + (P'(qhl_ff) <<< H) + (P'(qlh_ff) <<< H)
                   + P'(qll_ff);

   // stage D: compare and parity
   logic parity_ff, parity_in, inside_ff, inside_in;
   logic hit;

   always_comb begin
      hit       = cross_c_ff && (dpos_c_ff ? (lhs_ff < rhs_ff) : (rhs_ff < lhs_ff));
      parity_in = parity_ff;
      inside_in = inside_ff;
      if (ctl_c_ff.valid) begin
         parity_in = parity_ff ^ hit;
         if (ctl_c_ff.zone_end) begin
            inside_in = inside_ff || parity_in;
            parity_in = 1'b0;
         end
      end
      if (clear) begin
         parity_in = 1'b0;
         inside_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff  <= '0;
         ctl_b_ff  <= '0;
         ctl_c_ff  <= '0;
         parity_ff <= 1'b0;
         inside_ff <= 1'b0;
      end else begin
         ctl_a_ff  <= edge_ctl;
         ctl_b_ff  <= ctl_a_ff;
         ctl_c_ff  <= ctl_b_ff;
         parity_ff <= parity_in;
         inside_ff <= inside_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      d_ff       <= d_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      cross_a_ff <= cross_a_in;
      dpos_a_ff  <= dpos_a_in;
      phh_ff     <= phh_in;
      phl_ff     <= phl_in;
      plh_ff     <= plh_in;
      pll_ff     <= pll_in;
      qhh_ff     <= qhh_in;
      qhl_ff     <= qhl_in;
      qlh_ff     <= qlh_in;
      qll_ff     <= qll_in;
      cross_b_ff <= cross_a_ff;
      dpos_b_ff  <= dpos_a_ff;
      lhs_ff     <= lhs_in;
      rhs_ff     <= rhs_in;
      cross_c_ff <= cross_b_ff;
      dpos_c_ff  <= dpos_b_ff;
   end

   assign any_hit = inside_ff;
   assign busy    = ctl_a_ff.valid || ctl_b_ff.valid || ctl_c_ff.valid;

endmodule

// ===== hw/rtl/polygon_zone_membership.sv =====
// Top level of the polygon zone membership block: control, counters, bounds,
// register port and result register. Depends on pzm_pkg, pzm_edge_walk, pzm_cross_test.
//
//  channel | dir | handshake             | word
//  --------+-----+-----------------------+---------------------------------------------
//  req     | in  | req_valid / req_stall | mode, coord_x, coord_y, closes_zone
//  rsp     | out | rsp_valid / rsp_stall | inside_res, status, bounds_valid, bounds, zones
//  csr     | in  | psel/penable, pready  | enabled at byte address 0
//
// Clear, add vertex and idle modes, and queries with no zone stored or the block off,
// go from IDLE straight to FINISH, which loads the result word. A query with zones
// stored and the block enabled first walks V committed vertices in Z committed zones:
// the vertex memory read port delivers one vertex a cycle, pausing while a zone's
// closing edge goes out, and each zone adds its closing edge. One item is in work at
// a time; a new word is taken while the previous result word still waits on rsp_stall.
// Reset is synchronous; no clearing pass, the block takes words right after reset.

module polygon_zone_membership #(
   parameter int VERTEX_DEPTH = pzm_pkg::DEF_VERTEX_DEPTH,
   parameter int ZONE_DEPTH   = pzm_pkg::DEF_ZONE_DEPTH,
   parameter int COORD_BITS   = pzm_pkg::DEF_COORD_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [pzm_pkg::MODE_W-1:0]              req_mode,
   input  logic signed [pzm_pkg::PORT_COORD_W-1:0] req_coord_x,
   input  logic signed [pzm_pkg::PORT_COORD_W-1:0] req_coord_y,
   input  logic                                    req_closes_zone,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_inside_res,
   output logic [pzm_pkg::STATUS_W-1:0]            rsp_status,
   output logic                                    rsp_bounds_valid,
   output logic signed [pzm_pkg::PORT_COORD_W-1:0] rsp_bound_min_x,
   output logic signed [pzm_pkg::PORT_COORD_W-1:0] rsp_bound_min_y,
   output logic signed [pzm_pkg::PORT_COORD_W-1:0] rsp_bound_max_x,
   output logic signed [pzm_pkg::PORT_COORD_W-1:0] rsp_bound_max_y,
   output logic [pzm_pkg::ZONES_OUT_W-1:0]         rsp_zones_stored,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [pzm_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [pzm_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output logic [pzm_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);
   import pzm_pkg::*;

   localparam int AW = $clog2(VERTEX_DEPTH);
   localparam int CW = $clog2(VERTEX_DEPTH + 1);
   localparam int ZW = $clog2(ZONE_DEPTH + 1);
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [ZW-1:0] zone_total_ff, zone_total_in;
   logic [CW-1:0] committed_ff, committed_in;
   logic [CW-1:0] pending_ff, pending_in;
   logic          commit_ff, commit_in;
   logic          enabled_ff, enabled_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic signed [COORD_BITS-1:0] umin_x_ff, umin_x_in, umin_y_ff, umin_y_in;
   logic signed [COORD_BITS-1:0] umax_x_ff, umax_x_in, umax_y_ff, umax_y_in;
   logic signed [COORD_BITS-1:0] pmin_x_ff, pmin_x_in, pmin_y_ff, pmin_y_in;
   logic signed [COORD_BITS-1:0] pmax_x_ff, pmax_x_in, pmax_y_ff, pmax_y_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_inside_ff, rsp_inside_in;
   logic [STATUS_W-1:0]          rsp_status_ff, rsp_status_in;
   logic                         rsp_bvalid_ff, rsp_bvalid_in;
   logic signed [PORT_COORD_W-1:0] rsp_min_x_ff, rsp_min_x_in, rsp_min_y_ff, rsp_min_y_in;
   logic signed [PORT_COORD_W-1:0] rsp_max_x_ff, rsp_max_x_in, rsp_max_y_ff, rsp_max_y_in;
   logic [ZONES_OUT_W-1:0]       rsp_zones_ff, rsp_zones_in;

   logic signed [COORD_BITS-1:0] cx, cy;
   logic [CW-1:0] used;
   logic          store_full, long_poly, req_accept, bounds_ok;
   logic          wr_en, wr_last, walk_start;
   logic          walk_busy, test_busy, test_inside;
   edge_ctl_type  edge_ctl;
   logic signed [COORD_BITS-1:0] exi, eyi, exj, eyj;
   logic          csr_write, csr_hit;

   assign cx         = COORD_BITS'(req_coord_x);
   assign cy         = COORD_BITS'(req_coord_y);
   assign used       = CW'(committed_ff + pending_ff);
   assign store_full = (zone_total_ff >= ZW'(ZONE_DEPTH)) || (used >= CW'(VERTEX_DEPTH));
   assign long_poly  = pending_ff >= CW'(MIN_POLY_VERTICES - 1);
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign bounds_ok  = enabled_ff && (zone_total_ff != '0);

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_ENABLED);
   assign enabled_in = (csr_write && csr_hit) ? csr_pwdata[0] : enabled_ff;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(enabled_ff) : '0;

   always_comb begin
      state_in      = state_ff;
      zone_total_in = zone_total_ff;
      committed_in  = committed_ff;
      pending_in    = pending_ff;
      commit_in     = commit_ff;
      status_in     = status_ff;
      umin_x_in     = umin_x_ff;
      umin_y_in     = umin_y_ff;
      umax_x_in     = umax_x_ff;
      umax_y_in     = umax_y_ff;
      pmin_x_in     = pmin_x_ff;
      pmin_y_in     = pmin_y_ff;
      pmax_x_in     = pmax_x_ff;
      pmax_y_in     = pmax_y_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      wr_en         = 1'b0;
      wr_last       = 1'b0;
      walk_start    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_inside_in = rsp_inside_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_min_x_in  = rsp_min_x_ff;
      rsp_min_y_in  = rsp_min_y_ff;
      rsp_max_x_in  = rsp_max_x_ff;
      rsp_max_y_in  = rsp_max_y_ff;
      rsp_zones_in  = rsp_zones_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               status_in = STATUS_OK;
               commit_in = 1'b0;
               state_in  = ST_FINISH;
               case (req_mode)
                  MODE_CLEAR: begin
                     zone_total_in = '0;
                     committed_in  = '0;
                     pending_in    = '0;
                     umin_x_in     = COORD_MAX;
                     umin_y_in     = COORD_MAX;
                     umax_x_in     = COORD_MIN;
                     umax_y_in     = COORD_MIN;
                  end
                  MODE_ADD: begin
                     if (store_full) begin
                        status_in = STATUS_FULL;
                        if (req_closes_zone) begin
                           pending_in = '0;
                        end
                     end else begin
                        wr_en      = 1'b1;
                        wr_last    = req_closes_zone && long_poly;
                        pending_in = CW'(pending_ff + CW'(1));
                        // seed the open polygon's box on its first vertex
                        if (pending_ff == '0) begin
                           pmin_x_in = cx;
                           pmin_y_in = cy;
                           pmax_x_in = cx;
                           pmax_y_in = cy;
                        end else begin
                           pmin_x_in = (cx < pmin_x_ff) ? cx : pmin_x_ff;
                           pmin_y_in = (cy < pmin_y_ff) ? cy : pmin_y_ff;
                           pmax_x_in = (cx > pmax_x_ff) ? cx : pmax_x_ff;
                           pmax_y_in = (cy > pmax_y_ff) ? cy : pmax_y_ff;
                        end
                        if (req_closes_zone) begin
                           pending_in = '0;
                           if (!long_poly) begin
                              status_in = STATUS_SHORT;
                           end else begin
                              commit_in     = 1'b1;
                              committed_in  = CW'(committed_ff + pending_ff + CW'(1));
                              zone_total_in = ZW'(zone_total_ff + ZW'(1));
                           end
                        end
                     end
                  end
                  MODE_QUERY: begin
                     px_in = cx;
                     py_in = cy;
                     if (bounds_ok) begin
                        walk_start = 1'b1;
                        state_in   = ST_WALK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (!walk_busy && !test_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               // fold the just-closed polygon's box into the union
               if (commit_ff) begin
                  umin_x_in = (pmin_x_ff < umin_x_ff) ? pmin_x_ff : umin_x_ff;
                  umin_y_in = (pmin_y_ff < umin_y_ff) ? pmin_y_ff : umin_y_ff;
                  umax_x_in = (pmax_x_ff > umax_x_ff) ? pmax_x_ff : umax_x_ff;
                  umax_y_in = (pmax_y_ff > umax_y_ff) ? pmax_y_ff : umax_y_ff;
               end
               commit_in     = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_inside_in = test_inside;
               rsp_status_in = status_ff;
               rsp_bvalid_in = bounds_ok;
               rsp_min_x_in  = bounds_ok ? PORT_COORD_W'(umin_x_in) : '0;
               rsp_min_y_in  = bounds_ok ? PORT_COORD_W'(umin_y_in) : '0;
               rsp_max_x_in  = bounds_ok ? PORT_COORD_W'(umax_x_in) : '0;
               rsp_max_y_in  = bounds_ok ? PORT_COORD_W'(umax_y_in) : '0;
               rsp_zones_in  = ZONES_OUT_W'(zone_total_ff);
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         zone_total_ff <= '0;
         committed_ff  <= '0;
         pending_ff    <= '0;
         commit_ff     <= 1'b0;
         enabled_ff    <= 1'b1;
         status_ff     <= STATUS_OK;
         umin_x_ff     <= COORD_MAX;
         umin_y_ff     <= COORD_MAX;
         umax_x_ff     <= COORD_MIN;
         umax_y_ff     <= COORD_MIN;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         zone_total_ff <= zone_total_in;
         committed_ff  <= committed_in;
         pending_ff    <= pending_in;
         commit_ff     <= commit_in;
         enabled_ff    <= enabled_in;
         status_ff     <= status_in;
         umin_x_ff     <= umin_x_in;
         umin_y_ff     <= umin_y_in;
         umax_x_ff     <= umax_x_in;
         umax_y_ff     <= umax_y_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pmin_x_ff     <= pmin_x_in;
      pmin_y_ff     <= pmin_y_in;
      pmax_x_ff     <= pmax_x_in;
      pmax_y_ff     <= pmax_y_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_min_x_ff  <= rsp_min_x_in;
      rsp_min_y_ff  <= rsp_min_y_in;
      rsp_max_x_ff  <= rsp_max_x_in;
      rsp_max_y_ff  <= rsp_max_y_in;
      rsp_zones_ff  <= rsp_zones_in;
   end

   pzm_edge_walk #(
      .VERTEX_DEPTH (VERTEX_DEPTH),
      .COORD_BITS   (COORD_BITS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (used[AW-1:0]),
      .wr_x      (cx),
      .wr_y      (cy),
      .wr_last   (wr_last),
      .start     (walk_start),
      .vtx_count (committed_ff),
      .edge_ctl  (edge_ctl),
      .exi       (exi),
      .eyi       (eyi),
      .exj       (exj),
      .eyj       (eyj),
      .busy      (walk_busy)
   );

   pzm_cross_test #(
      .COORD_BITS (COORD_BITS)
   ) u_test (
      .clock    (clock),
      .reset    (reset),
      .clear    (req_accept),
      .edge_ctl (edge_ctl),
      .exi      (exi),
      .eyi      (eyi),
      .exj      (exj),
      .eyj      (eyj),
      .px       (px_ff),
      .py       (py_ff),
      .any_hit  (test_inside),
      .busy     (test_busy)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inside_res   = rsp_inside_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bounds_valid = rsp_bvalid_ff;
   assign rsp_bound_min_x  = rsp_min_x_ff;
   assign rsp_bound_min_y  = rsp_min_y_ff;
   assign rsp_bound_max_x  = rsp_max_x_ff;
   assign rsp_bound_max_y  = rsp_max_y_ff;
   assign rsp_zones_stored = rsp_zones_ff;

   // zone count and committed vertex count empty together
   a_counts_agree: assert property (@(posedge clock) disable iff (reset)
      (zone_total_ff == '0) == (committed_ff == '0))
      else $error("zone count and committed vertex count disagree");

   // vertex slots in use never exceed the memory
   a_slots_bounded: assert property (@(posedge clock) disable iff (reset)
      (CW + 1)'(committed_ff) + (CW + 1)'(pending_ff) <= (CW + 1)'(VERTEX_DEPTH))
      else $error("vertex slots overrun the vertex memory");

   // no result word is formed while edges are still in flight
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (!walk_busy && !test_busy))
      else $error("result formed with edge walk still busy");

   // a new result word only follows the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall) && !$past(reset))
         |-> ($past(state_ff) == ST_FINISH))
      else $error("result word loaded outside the finish step");

endmodule
